// ----- hw/rtl/rffp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rffp_pkg: shared types and constants for the range/flow frame parser
// Header bytes, frame constants, queue beat opcodes and the beat type passed
// from the byte classifier to the frame executor.
// ---------------------------------------------------------------------------
package rffp_pkg;

  localparam logic [7:0] HDR0_BYTE   = 8'hDF;
  localparam logic [7:0] HDR1_BYTE   = 8'h15;
  localparam logic [7:0] HDR2_BYTE   = 8'h00;
  localparam logic [7:0] HDR3_BYTE   = 8'h55;
  localparam logic [7:0] FRAME_LEN_BYTE = 8'h0C;
  localparam logic [7:0] FLOW_MARK_BYTE = 8'hF5;
  localparam logic [7:0] THRESH_RESET   = 8'd40;

  localparam int PAYLOAD_LEN   = 12;
  localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_LEN);
  localparam logic [PAYLOAD_IDX_W-1:0] PAYLOAD_LAST = PAYLOAD_IDX_W'(PAYLOAD_LEN - 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  // Beat opcodes from front to back
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_START = 3'd0;  // first header byte: load sum
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;  // fixed byte: add to sum
  localparam logic [OP_W-1:0] OP_SEQ   = 3'd2;  // sequence byte: hold and add
  localparam logic [OP_W-1:0] OP_DATA  = 3'd3;  // payload byte: store and add
  localparam logic [OP_W-1:0] OP_SUM   = 3'd4;  // checksum byte: emit result

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [PAYLOAD_IDX_W-1:0] idx;
    logic [7:0]               data;
  } beat_t;

endpackage

// ----- hw/rtl/rffp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rffp_if: channel interfaces of the frame parser
// Byte input channel and decoded frame result channel, valid/ready.
// ---------------------------------------------------------------------------
interface rffp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rffp_out_if;
  logic               valid;
  logic               ready;
  logic               checksum_ok;
  logic [7:0]         sequence_number;
  logic [15:0]        distance_mm;
  logic [7:0]         signal_strength;
  logic               range_valid;
  logic               flow_valid;
  logic signed [15:0] flow_x_raw;
  logic signed [15:0] flow_y_raw;
  logic signed [15:0] flow_interval;
  logic [7:0]         sensor_version;

  modport source (output valid, output checksum_ok, output sequence_number,
                  output distance_mm, output signal_strength, output range_valid,
                  output flow_valid, output flow_x_raw, output flow_y_raw,
                  output flow_interval, output sensor_version, input ready);
  modport sink   (input valid, input checksum_ok, input sequence_number,
                  input distance_mm, input signal_strength, input range_valid,
                  input flow_valid, input flow_x_raw, input flow_y_raw,
                  input flow_interval, input sensor_version, output ready);
endinterface

// ----- hw/rtl/rffp_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rffp_front: byte classifier
// Tracks the frame phase and turns each accepted byte into a queue beat;
// bytes that do not belong to a frame are dropped here.
// ---------------------------------------------------------------------------
module rffp_front import rffp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rffp_in_if.sink     in_ch,
  input  logic        q_full,
  output logic        push_valid,
  output beat_t       push_beat
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_H1   = 3'd1;
  localparam logic [2:0] PH_H2   = 3'd2;
  localparam logic [2:0] PH_H3   = 3'd3;
  localparam logic [2:0] PH_SEQ  = 3'd4;
  localparam logic [2:0] PH_LEN  = 3'd5;
  localparam logic [2:0] PH_DATA = 3'd6;
  localparam logic [2:0] PH_SUM  = 3'd7;

  logic [2:0]               phase_r, phase_nxt;
  logic [PAYLOAD_IDX_W-1:0] count_r, count_nxt;
  logic                     accept;
  logic                     emit;
  logic [OP_W-1:0]          op;
  logic [7:0]               b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    emit      = 1'b0;
    op        = OP_ADD;
    unique case (phase_r)
      PH_HUNT: begin
        if (b == HDR0_BYTE) begin
          emit      = 1'b1;
          op        = OP_START;
          phase_nxt = PH_H1;
        end
      end
      PH_H1, PH_H2, PH_H3: begin
        if ((phase_r == PH_H1 && b == HDR1_BYTE) ||
            (phase_r == PH_H2 && b == HDR2_BYTE) ||
            (phase_r == PH_H3 && b == HDR3_BYTE)) begin
          emit      = 1'b1;
          phase_nxt = phase_r + 3'd1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SEQ: begin
        emit      = 1'b1;
        op        = OP_SEQ;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (b == FRAME_LEN_BYTE) begin
          emit      = 1'b1;
          count_nxt = '0;
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        op   = OP_DATA;
        if (count_r == PAYLOAD_LAST) begin
          count_nxt = '0;
          phase_nxt = PH_SUM;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      PH_SUM: begin
        emit      = 1'b1;
        op        = OP_SUM;
        count_nxt = '0;
        phase_nxt = PH_HUNT;
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  assign push_valid     = accept && emit;
  assign push_beat.op   = op;
  assign push_beat.idx  = count_r;
  assign push_beat.data = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/rffp_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rffp_queue: beat queue between classifier and executor
// Small register FIFO so that either side can stall on its own.
// ---------------------------------------------------------------------------
module rffp_queue import rffp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  beat_t push_beat,
  output logic  full,
  output logic  pop_valid,
  output beat_t pop_beat,
  input  logic  pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  beat_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_beat  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rffp_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rffp_back: frame executor
// Keeps the running sum, sequence byte and payload bytes, and decodes a
// result into the output register on each checksum beat.
// ---------------------------------------------------------------------------
module rffp_back import rffp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        q_valid,
  input  beat_t       q_beat,
  output logic        q_ready,
  rffp_out_if.source  out_ch
);

  logic [7:0]         thresh_r;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         seq_r;
  logic [7:0]         store_r [PAYLOAD_LEN];
  logic               out_valid_r;
  logic               chk_ok_r;
  logic [7:0]         seq_out_r;
  logic [15:0]        dist_r;
  logic [7:0]         strength_r;
  logic               rv_r, fv_r;
  logic signed [15:0] fx_r, fy_r, fint_r;
  logic [7:0]         ver_r;
  logic               pop;
  logic               is_sum;
  logic               rv, fv;

  assign is_sum  = (q_beat.op == OP_SUM);
  // a checksum beat waits for the output register; everything else flows
  assign q_ready = !is_sum || !out_valid_r || out_ch.ready;
  assign pop     = q_valid && q_ready;
  assign sum_nxt = sum_r + q_beat.data;

  assign rv = (store_r[2] > thresh_r);
  assign fv = rv && (store_r[10] == FLOW_MARK_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      seq_r <= '0;
    end else if (pop) begin
      unique case (q_beat.op)
        OP_START: sum_r <= q_beat.data;
        OP_ADD:   sum_r <= sum_nxt;
        OP_SEQ: begin
          seq_r <= q_beat.data;
          sum_r <= sum_nxt;
        end
        OP_DATA:  sum_r <= sum_nxt;
        OP_SUM:   ;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_beat.op == OP_DATA) begin
      store_r[q_beat.idx] <= q_beat.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && is_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_sum) begin
      chk_ok_r   <= (sum_r == q_beat.data);
      seq_out_r  <= seq_r;
      dist_r     <= {store_r[1], store_r[0]};
      strength_r <= store_r[2];
      rv_r       <= rv;
      fv_r       <= fv;
      // zero the flow words unless the frame carries valid flow
      fx_r       <= fv ? signed'({store_r[5], store_r[4]}) : '0;
      fy_r       <= fv ? signed'({store_r[7], store_r[6]}) : '0;
      fint_r     <= fv ? signed'({store_r[9], store_r[8]}) : '0;
      ver_r      <= store_r[11];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.checksum_ok     = chk_ok_r;
  assign out_ch.sequence_number = seq_out_r;
  assign out_ch.distance_mm     = dist_r;
  assign out_ch.signal_strength = strength_r;
  assign out_ch.range_valid     = rv_r;
  assign out_ch.flow_valid      = fv_r;
  assign out_ch.flow_x_raw      = fx_r;
  assign out_ch.flow_y_raw      = fy_r;
  assign out_ch.flow_interval   = fint_r;
  assign out_ch.sensor_version  = ver_r;

endmodule

// ----- hw/rtl/range_flow_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_flow_frame_parser_unit: range and optical-flow serial frame parser
// Hunts for header DF 15 00 55, checks the additive checksum and decodes
// the twelve-byte payload into one result per frame.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake     | beat payload
//  ---------+-----+---------------+----------------------------------------
//  in_ch    | in  | valid/ready   | rx_byte
//  out_ch   | out | valid/ready   | checksum_ok .. sensor_version
//  cfg_*    | in  | cfg_wr_en     | cfg_wr_data = strength_threshold
//
//  One byte is taken per cycle; the classifier settles the frame phase in
//  that cycle, and the executor takes one queued beat per cycle.
//  A result is registered once its checksum beat leaves the beat queue.
//  Reset is synchronous; it empties the beat queue and the output register.
//  A stalled result holds back only the next checksum beat; QUEUE_DEPTH - 1
//  further beats queue behind it before in_ch.ready drops.
// ---------------------------------------------------------------------------
module range_flow_frame_parser_unit import rffp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rffp_in_if.sink    in_ch,
  rffp_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic  push_valid;
  beat_t push_beat;
  logic  q_full;
  logic  q_valid;
  beat_t q_beat;
  logic  q_ready;

  rffp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_beat  (push_beat)
  );

  rffp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_beat  (push_beat),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_beat   (q_beat),
    .pop_ready  (q_ready)
  );

  rffp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_beat      (q_beat),
    .q_ready     (q_ready),
    .out_ch      (out_ch)
  );

endmodule

// ----- hw/rtl/rffp_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rffp_checker: port-level checks for the frame parser
// Watches the top-level channels; attached by bind.
// ---------------------------------------------------------------------------
module rffp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_range_valid,
  input logic        out_flow_valid,
  input logic [15:0] out_flow_x_raw,
  input logic [15:0] out_flow_y_raw,
  input logic [15:0] out_flow_interval,
  input logic [15:0] out_distance_mm
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_mm) &&
    $stable(out_flow_valid))
    else $error("stalled result beat changed");

  a_flow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_flow_valid |->
    out_flow_x_raw == 16'd0 && out_flow_y_raw == 16'd0 && out_flow_interval == 16'd0)
    else $error("flow words nonzero without flow_valid");

  a_flow_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flow_valid |-> out_range_valid)
    else $error("flow_valid without range_valid");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind range_flow_frame_parser_unit rffp_checker u_rffp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_range_valid   (out_ch.range_valid),
  .out_flow_valid    (out_ch.flow_valid),
  .out_flow_x_raw    (out_ch.flow_x_raw),
  .out_flow_y_raw    (out_ch.flow_y_raw),
  .out_flow_interval (out_ch.flow_interval),
  .out_distance_mm   (out_ch.distance_mm)
);
